/* rtl/spd_pkg.sv */
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types, codes and the CRC fold for the serial packet deframer.
// ----------------------------------------------------------------------------
package spd_pkg;

    // Parser phase codes (4-bit state vector).
    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_START2 = 4'd1;
    localparam logic [3:0] PH_START3 = 4'd2;
    localparam logic [3:0] PH_LENL   = 4'd3;
    localparam logic [3:0] PH_LENH   = 4'd4;
    localparam logic [3:0] PH_TYPE   = 4'd5;
    localparam logic [3:0] PH_DATA   = 4'd6;
    localparam logic [3:0] PH_CRCL   = 4'd7;
    localparam logic [3:0] PH_CRCH   = 4'd8;
    localparam logic [3:0] PH_END1   = 4'd9;
    localparam logic [3:0] PH_END2   = 4'd10;
    localparam logic [3:0] PH_END3   = 4'd11;

    // Result kinds.
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [1:0] KIND_ABORT   = 2'd2;

    // Mark characters and CRC seed.
    localparam logic [7:0]  CHAR_GT    = 8'h3E; // '>'
    localparam logic [7:0]  CHAR_STAR  = 8'h2A; // '*'
    localparam logic [7:0]  CHAR_LT    = 8'h3C; // '<'
    localparam logic [7:0]  CHAR_HASH  = 8'h23; // '#'
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;

    // One result item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [7:0]  frame_type;
        logic [15:0] frame_length;
    } res_t;

    // Byte-wide update of the reflected CCITT CRC (polynomial 0x8408).
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
        logic [7:0]  d;
        logic [15:0] d16;
        d   = data ^ crc[7:0];
        d   = d ^ {d[3:0], 4'b0000};
        d16 = {8'h00, d};
        crc_fold = {d, crc[15:8]} ^ (d16 >> 4) ^ (d16 << 3);
    endfunction

endpackage

/* rtl/spd_rx_if.sv */
// ----------------------------------------------------------------------------
// spd_rx_if
// Received-byte channel: valid/ready handshake carrying one byte per item.
// ----------------------------------------------------------------------------
interface spd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/spd_res_if.sv */
// ----------------------------------------------------------------------------
// spd_res_if
// Result channel: payload bytes and frame accept/abort indications.
// ----------------------------------------------------------------------------
interface spd_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;

    modport source (output valid, output kind, output payload_byte, output frame_type,
                    output frame_length, input ready);
    modport sink   (input valid, input kind, input payload_byte, input frame_type,
                    input frame_length, output ready);
endinterface

/* rtl/serial_packet_deframer_crc16.sv */
// ----------------------------------------------------------------------------
// serial_packet_deframer_crc16
// Parses '>*>' len(2) type payload crc(2) '<#<' frames from a byte stream,
// streams the payload out and reports each frame as accepted or aborted.
// ----------------------------------------------------------------------------
//
//   Channel | Modport | Direction | Contents
//   --------+---------+-----------+------------------------------------------
//   rx      | sink    | in        | rx_byte, one received byte per item
//   res     | source  | out       | kind, payload_byte, frame_type,
//           |         |           | frame_length, zero or one per input item
//
// Every byte is parsed in the cycle in which it is accepted, so one item is
// taken per clock while the skid register is empty. Results pass through an
// output register backed by a one-entry skid register; rx.ready drops only
// while the skid register is occupied. Reset (rst_n low, asynchronous)
// returns the parser to idle with the CRC seeded to 0xFFFF and both result
// registers empty.
//
module serial_packet_deframer_crc16
    import spd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    spd_rx_if.sink     rx,
    spd_res_if.source  res
);

    // ------------------------------------------------------------------
    // Parser state.
    // ------------------------------------------------------------------
    logic [3:0]  phase_reg,    phase_next;
    logic [15:0] exp_len_reg,  exp_len_next;
    logic [15:0] seen_reg,     seen_next;
    logic [15:0] crc_reg,      crc_next;
    logic [7:0]  crc_lo_reg,   crc_lo_next;
    logic [7:0]  type_reg,     type_next;

    // Output register and skid register.
    logic        out_valid_reg,  out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    res_t        out_data_reg,   out_data_next;
    res_t        skid_data_reg,  skid_data_next;

    logic        accept;
    logic        has_result;
    logic [1:0]  result_kind;
    logic [7:0]  result_byte;
    res_t        result;
    logic        res_fire;
    logic        out_free;
    logic [15:0] seen_inc;
    logic [15:0] rx_crc;
    logic [7:0]  c;

    assign rx.ready = !skid_valid_reg;
    assign accept   = rx.valid && rx.ready;
    assign c        = rx.rx_byte;
    assign seen_inc = seen_reg + 16'd1;
    assign rx_crc   = {c, crc_lo_reg};

    // ------------------------------------------------------------------
    // Frame parser: next state and the result of the current byte.
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next   = phase_reg;
        exp_len_next = exp_len_reg;
        seen_next    = seen_reg;
        crc_next     = crc_reg;
        crc_lo_next  = crc_lo_reg;
        type_next    = type_reg;
        has_result   = 1'b0;
        result_kind  = KIND_PAYLOAD;
        result_byte  = 8'h00;

        unique case (phase_reg)
            PH_IDLE:   phase_next = (c == CHAR_GT)   ? PH_START2 : PH_IDLE;
            PH_START2: phase_next = (c == CHAR_STAR) ? PH_START3 : PH_IDLE;
            PH_START3: phase_next = (c == CHAR_GT)   ? PH_LENL   : PH_IDLE;
            PH_LENL:
            begin
                exp_len_next = {8'h00, c};
                phase_next   = PH_LENH;
            end
            PH_LENH:
            begin
                exp_len_next = {c, exp_len_reg[7:0]};
                seen_next    = 16'd0;
                crc_next     = CRC_INIT;
                phase_next   = PH_TYPE;
            end
            PH_TYPE:
            begin
                // An empty payload skips straight to the CRC bytes.
                type_next  = c;
                phase_next = (exp_len_reg == 16'd0) ? PH_CRCL : PH_DATA;
            end
            PH_DATA:
            begin
                crc_next    = crc_fold(crc_reg, c);
                seen_next   = seen_inc;
                if (seen_inc >= exp_len_reg)
                begin
                    phase_next = PH_CRCL;
                end
                has_result  = 1'b1;
                result_kind = KIND_PAYLOAD;
                result_byte = c;
            end
            PH_CRCL:
            begin
                crc_lo_next = c;
                phase_next  = PH_CRCH;
            end
            PH_CRCH:
            begin
                if (rx_crc == crc_reg)
                begin
                    phase_next = PH_END1;
                end
                else
                begin
                    phase_next  = PH_IDLE;
                    has_result  = 1'b1;
                    result_kind = KIND_ABORT;
                end
            end
            PH_END1:
            begin
                if (c == CHAR_LT)
                begin
                    phase_next = PH_END2;
                end
                else
                begin
                    phase_next  = PH_IDLE;
                    has_result  = 1'b1;
                    result_kind = KIND_ABORT;
                end
            end
            PH_END2:
            begin
                if (c == CHAR_HASH)
                begin
                    phase_next = PH_END3;
                end
                else
                begin
                    phase_next  = PH_IDLE;
                    has_result  = 1'b1;
                    result_kind = KIND_ABORT;
                end
            end
            PH_END3:
            begin
                phase_next  = PH_IDLE;
                has_result  = 1'b1;
                result_kind = (c == CHAR_LT) ? KIND_ACCEPT : KIND_ABORT;
            end
            default:   phase_next = PH_IDLE;
        endcase
    end

    // The frame fields are taken after this byte's update, as the stream
    // defines them.
    always_comb
    begin
        result.kind         = result_kind;
        result.payload_byte = result_byte;
        result.frame_type   = type_next;
        result.frame_length = exp_len_next;
    end

    // ------------------------------------------------------------------
    // Output register with skid stage.
    // ------------------------------------------------------------------
    assign res_fire = accept && has_result;
    assign out_free = !out_valid_reg || res.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                // No item is accepted while the skid register is full.
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_fire;
                if (res_fire)
                begin
                    out_data_next = result;
                end
            end
        end
        else if (res_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            exp_len_reg    <= 16'd0;
            seen_reg       <= 16'd0;
            crc_reg        <= CRC_INIT;
            crc_lo_reg     <= 8'h00;
            type_reg       <= 8'h00;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg   <= phase_next;
                exp_len_reg <= exp_len_next;
                seen_reg    <= seen_next;
                crc_reg     <= crc_next;
                crc_lo_reg  <= crc_lo_next;
                type_reg    <= type_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.kind         = out_data_reg.kind;
    assign res.payload_byte = out_data_reg.payload_byte;
    assign res.frame_type   = out_data_reg.frame_type;
    assign res.frame_length = out_data_reg.frame_length;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds an item while the output register is empty");

    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_END3)
        else $error("parser phase outside the defined range");

    a_data_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_DATA) |=> out_valid_reg)
        else $error("payload byte accepted without a result");

    a_status_clean_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.kind != KIND_PAYLOAD)
            |-> (out_data_reg.payload_byte == 8'h00))
        else $error("frame status result carries a payload byte");

endmodule

/* tb/sv/serial_packet_deframer_crc16_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_packet_deframer_crc16_tb
// Self-checking bench for the byte-stream deframer with CRC-16 check.
// Frames, broken frames and noise are pushed through the rx channel while a
// parser model tracks every accepted byte. Each result on the res channel is
// compared field by field with the oldest predicted event.
// ----------------------------------------------------------------------------
module serial_packet_deframer_crc16_tb
    import spd_pkg::*;
();

    // Reflected CCITT polynomial, applied one bit at a time below.
    localparam logic [15:0] CCITT_POLY_REFL = 16'h8408;
    // Longest deliberate hold-off on the result side, in cycles.
    localparam int HOLD_CYCLES = 64;
    // Cycles with no item moving on either channel before the run is abandoned.
    // The longest legal quiet stretch is the hold-off plus a stall burst.
    localparam int QUIET_LIMIT = 1000;
    // Cycles allowed after the last expected result for stray results to show.
    localparam int TAIL_CYCLES = 8;
    // Minimum number of frame bytes sent in the main random phase.
    localparam int RANDOM_ITEMS = 40;

    typedef logic [7:0] byte_q_t[$];

    // How a generated frame is to be damaged, if at all.
    typedef enum int {
        FRAME_OK,
        FRAME_BAD_CRC,
        FRAME_BAD_END1,
        FRAME_BAD_END2,
        FRAME_BAD_END3,
        FRAME_BAD_START2,
        FRAME_BAD_START3
    } frame_fault_t;

    logic clk;
    logic rst_n;

    spd_rx_if  rx_ch ();
    spd_res_if res_ch ();

    serial_packet_deframer_crc16 dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch)
    );

    // Parser model state. It mirrors the block's own registers and is only
    // advanced when a byte is actually accepted on the rx channel.
    logic [3:0]  parse_state;
    logic [15:0] frame_len;
    logic [15:0] payload_count;
    logic [15:0] payload_crc;
    logic [7:0]  crc_low;
    logic [7:0]  frame_kind;

    // Predicted results, oldest first.
    res_t pending_events[$];

    int  error_count = 0;
    int  frame_items;
    int  quiet_cycles;
    bit  tx_gaps_on;
    bit  rx_stalls_on;
    int  hold_requests;

    // ------------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // CRC and parser model.
    // ------------------------------------------------------------------------

    // Bit-serial form of the reflected CCITT update. It is the long-hand
    // version of the byte-wide fold the hardware uses, so the two are
    // independent ways of reaching the same value.
    function automatic logic [15:0] crc16_ccitt_step(input logic [15:0] crc,
                                                     input logic [7:0]  data);
        logic [15:0] r;
        r = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (r[0])
                r = (r >> 1) ^ CCITT_POLY_REFL;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    // Every result carries the type and length of the frame in progress.
    function automatic void queue_event(input logic [1:0] kind, input logic [7:0] data);
        res_t ev;
        ev.kind         = kind;
        ev.payload_byte = data;
        ev.frame_type   = frame_kind;
        ev.frame_length = frame_len;
        pending_events.push_back(ev);
    endfunction

    // Advances the parser model by one accepted byte and records any result.
    function automatic void deframe_byte(input logic [7:0] c);
        logic [15:0] rx_crc;
        case (parse_state)
            PH_IDLE:
                parse_state = (c == CHAR_GT) ? PH_START2 : PH_IDLE;
            PH_START2:
                parse_state = (c == CHAR_STAR) ? PH_START3 : PH_IDLE;
            PH_START3:
                parse_state = (c == CHAR_GT) ? PH_LENL : PH_IDLE;
            PH_LENL:
            begin
                frame_len   = {8'h00, c};
                parse_state = PH_LENH;
            end
            PH_LENH:
            begin
                // The CRC is seeded afresh once the length is complete.
                frame_len     = {c, frame_len[7:0]};
                payload_count = 16'h0000;
                payload_crc   = CRC_INIT;
                parse_state   = PH_TYPE;
            end
            PH_TYPE:
            begin
                // An empty payload skips straight to the CRC field.
                frame_kind  = c;
                parse_state = (frame_len == 16'h0000) ? PH_CRCL : PH_DATA;
            end
            PH_DATA:
            begin
                payload_crc   = crc16_ccitt_step(payload_crc, c);
                payload_count = payload_count + 16'h0001;
                if (payload_count >= frame_len)
                    parse_state = PH_CRCL;
                queue_event(KIND_PAYLOAD, c);
            end
            PH_CRCL:
            begin
                crc_low     = c;
                parse_state = PH_CRCH;
            end
            PH_CRCH:
            begin
                rx_crc = {c, crc_low};
                if (rx_crc == payload_crc)
                    parse_state = PH_END1;
                else
                begin
                    parse_state = PH_IDLE;
                    queue_event(KIND_ABORT, 8'h00);
                end
            end
            PH_END1:
            begin
                if (c == CHAR_LT)
                    parse_state = PH_END2;
                else
                begin
                    parse_state = PH_IDLE;
                    queue_event(KIND_ABORT, 8'h00);
                end
            end
            PH_END2:
            begin
                if (c == CHAR_HASH)
                    parse_state = PH_END3;
                else
                begin
                    parse_state = PH_IDLE;
                    queue_event(KIND_ABORT, 8'h00);
                end
            end
            PH_END3:
            begin
                parse_state = PH_IDLE;
                queue_event((c == CHAR_LT) ? KIND_ACCEPT : KIND_ABORT, 8'h00);
            end
            default:
                parse_state = PH_IDLE;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Offers one byte on rx, possibly after a short idle burst, and waits
    // until it is taken. valid is left high so that back-to-back items need
    // no second assignment in the same time step.
    task automatic send_rx_byte(input logic [7:0] b);
        int gap;
        if (tx_gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        deframe_byte(b);
    endtask

    task automatic send_bytes(input byte_q_t bytes);
        foreach (bytes[i])
            send_rx_byte(bytes[i]);
    endtask

    // Any byte value except the one given, used to break a mark.
    function automatic logic [7:0] other_than(input logic [7:0] avoid);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == avoid);
        return b;
    endfunction

    function automatic byte_q_t random_body(input int n);
        byte_q_t q;
        for (int i = 0; i < n; i++)
            q.push_back(8'($urandom_range(0, 255)));
        return q;
    endfunction

    // Builds a complete frame around the given payload, damages it as asked
    // and sends it. The length field is taken as given, so it normally
    // matches the payload size.
    task automatic send_frame(input logic [15:0] len, input logic [7:0] ftype,
                              input frame_fault_t fault, input byte_q_t body);
        byte_q_t     fb;
        logic [15:0] crc;
        crc = CRC_INIT;
        foreach (body[i])
            crc = crc16_ccitt_step(crc, body[i]);
        if (fault == FRAME_BAD_CRC)
            crc ^= (16'h0001 << $urandom_range(0, 15));
        fb.push_back(CHAR_GT);
        fb.push_back((fault == FRAME_BAD_START2) ? other_than(CHAR_STAR) : CHAR_STAR);
        fb.push_back((fault == FRAME_BAD_START3) ? other_than(CHAR_GT) : CHAR_GT);
        fb.push_back(len[7:0]);
        fb.push_back(len[15:8]);
        fb.push_back(ftype);
        foreach (body[i])
            fb.push_back(body[i]);
        fb.push_back(crc[7:0]);
        fb.push_back(crc[15:8]);
        fb.push_back((fault == FRAME_BAD_END1) ? other_than(CHAR_LT) : CHAR_LT);
        fb.push_back((fault == FRAME_BAD_END2) ? other_than(CHAR_HASH) : CHAR_HASH);
        fb.push_back((fault == FRAME_BAD_END3) ? other_than(CHAR_LT) : CHAR_LT);
        frame_items += fb.size();
        send_bytes(fb);
    endtask

    // One random frame, mostly well formed and short, sometimes damaged in
    // one place, now and then replaced by a little line noise.
    task automatic send_random_frame();
        int           sel;
        int           size_sel;
        int           n;
        frame_fault_t fault;
        sel      = $urandom_range(0, 99);
        size_sel = $urandom_range(0, 19);
        if (size_sel < 16)
            n = $urandom_range(0, 10);
        else if (size_sel < 19)
            n = $urandom_range(11, 40);
        else
            n = $urandom_range(100, 250);
        if (sel < 68)
            fault = FRAME_OK;
        else if (sel < 76)
            fault = FRAME_BAD_CRC;
        else if (sel < 80)
            fault = FRAME_BAD_END1;
        else if (sel < 84)
            fault = FRAME_BAD_END2;
        else if (sel < 88)
            fault = FRAME_BAD_END3;
        else if (sel < 92)
            fault = FRAME_BAD_START2;
        else if (sel < 96)
            fault = FRAME_BAD_START3;
        else
        begin
            // Noise is mostly ignored by an idle parser, so it is not counted
            // as frame traffic. Start bytes are salted in to provoke false
            // starts.
            repeat ($urandom_range(1, 4))
                send_rx_byte(($urandom_range(0, 3) == 0) ? CHAR_GT
                                                         : 8'($urandom_range(0, 255)));
            return;
        end
        send_frame(16'(n), 8'($urandom_range(0, 255)), fault, random_body(n));
    endtask

    // ------------------------------------------------------------------------
    // Checking.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
        error_count++;
    endtask

    // Each accepted result is matched against the oldest predicted event.
    initial
    begin : result_checker
        res_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                if (pending_events.size() == 0)
                    report_mismatch("result with nothing pending, kind",
                                    32'(res_ch.kind), 32'd0);
                else
                begin
                    want = pending_events.pop_front();
                    if (res_ch.kind !== want.kind)
                        report_mismatch("kind", 32'(res_ch.kind), 32'(want.kind));
                    if (res_ch.payload_byte !== want.payload_byte)
                        report_mismatch("payload_byte", 32'(res_ch.payload_byte),
                                        32'(want.payload_byte));
                    if (res_ch.frame_type !== want.frame_type)
                        report_mismatch("frame_type", 32'(res_ch.frame_type),
                                        32'(want.frame_type));
                    if (res_ch.frame_length !== want.frame_length)
                        report_mismatch("frame_length", 32'(res_ch.frame_length),
                                        32'(want.frame_length));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result-side flow control. Random stall bursts while enabled, and on
    // request one long hold-off so that the block's output registers fill and
    // it has to push back on its input.
    // ------------------------------------------------------------------------
    initial
    begin : result_receiver
        int holds_served;
        holds_served = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served < hold_requests)
            begin
                holds_served++;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
            else if (rx_stalls_on && $urandom_range(0, 3) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: the run is abandoned if nothing moves on either channel for
    // far longer than any correct run would need.
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("serial_packet_deframer_crc16_tb: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // An empty payload goes straight to the CRC, which must then equal the
    // seed. The type byte takes its top value, then zero with a bad CRC.
    task automatic test_zero_length();
        byte_q_t none;
        send_frame(16'h0000, 8'hFF, FRAME_OK, none);
        send_frame(16'h0000, 8'h00, FRAME_BAD_CRC, none);
    endtask

    // Short frames with payload bytes at both extremes.
    task automatic test_short_frames();
        byte_q_t body;
        body = '{8'hFF};
        send_frame(16'h0001, 8'h00, FRAME_OK, body);
        body = '{8'h00, 8'h80};
        send_frame(16'h0002, 8'h7F, FRAME_OK, body);
    endtask

    // A payload whose CRC does not match is streamed, then aborted.
    task automatic test_crc_mismatch();
        byte_q_t body;
        body = '{8'h55};
        send_frame(16'h0001, 8'hA5, FRAME_BAD_CRC, body);
    endtask

    // Each of the three end-mark bytes broken in turn. The last sequence
    // breaks the end mark with a start byte: that byte is not rescanned, so
    // the start-like bytes after it must not open a frame.
    task automatic test_broken_end();
        byte_q_t none;
        byte_q_t seq;
        send_frame(16'h0000, 8'h5A, FRAME_BAD_END1, none);
        send_frame(16'h0000, 8'h5B, FRAME_BAD_END2, none);
        send_frame(16'h0000, 8'h5C, FRAME_BAD_END3, none);
        seq = '{CHAR_GT, CHAR_STAR, CHAR_GT, 8'h00, 8'h00, 8'h11, 8'hFF, 8'hFF,
                CHAR_GT, CHAR_STAR, CHAR_GT, 8'h02};
        send_bytes(seq);
    endtask

    // A broken start mark returns the parser to idle, and the breaking byte
    // is not taken as a fresh start byte even when it is one. A clean frame
    // afterwards shows the parser has recovered.
    task automatic test_broken_start();
        byte_q_t none;
        byte_q_t seq;
        seq = '{CHAR_GT, CHAR_GT, CHAR_STAR, CHAR_GT, CHAR_GT, CHAR_STAR, CHAR_STAR};
        send_bytes(seq);
        send_frame(16'h0000, 8'h42, FRAME_OK, none);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering payload bytes with no gaps, so the block must stall its input.
    // The frame is long enough for both length bytes to be non-zero.
    task automatic test_backpressure();
        tx_gaps_on = 1'b0;
        hold_requests++;
        send_frame(16'h0101, 8'hC3, FRAME_OK, random_body(257));
        tx_gaps_on = 1'b1;
    endtask

    // The main random phase, with idling on both sides.
    task automatic test_random_traffic();
        int base;
        base = frame_items;
        while (frame_items - base < RANDOM_ITEMS)
            send_random_frame();
    endtask

    // The closing stretch runs at full rate with no idling anywhere.
    task automatic test_full_rate();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        repeat (2)
            send_random_frame();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        frame_items   = 0;
        tx_gaps_on    = 1'b1;
        rx_stalls_on  = 1'b1;
        hold_requests = 0;
        parse_state   = PH_IDLE;
        frame_len     = 16'h0000;
        payload_count = 16'h0000;
        payload_crc   = CRC_INIT;
        crc_low       = 8'h00;
        frame_kind    = 8'h00;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_length();
        test_short_frames();
        test_crc_mismatch();
        test_broken_end();
        test_broken_start();
        test_backpressure();
        test_random_traffic();
        test_full_rate();

        // Stop offering, let every predicted result drain, then wait TAIL_CYCLES
        // for any stray result to appear.
        rx_ch.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("serial_packet_deframer_crc16_tb: clean");
        else
            $display("serial_packet_deframer_crc16_tb: errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/spd_pkg.sv
rtl/spd_rx_if.sv
rtl/spd_res_if.sv
rtl/serial_packet_deframer_crc16.sv
tb/sv/serial_packet_deframer_crc16_tb.sv
